/* sv/pspr_pkg.sv */
package pspr_pkg;

   // Ring geometry
   localparam int RingDepth = 256;
   localparam int RingAw    = $clog2(RingDepth);

   // Pose ring entry: stamp, position, angles
   localparam int PoseW = 48 + 96 + 48;

   // Register map
   localparam logic [0:0] RegInitSkip = 1'b0;

   // Input action codes
   localparam logic ActPose  = 1'b0;
   localparam logic ActPoint = 1'b1;

   // Item queued between front and back
   typedef struct packed {
      logic        is_scan;   // first point of an accepted scan
      logic        is_point;  // point to transform
      logic [47:0] stamp;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } item_type;

   localparam int ItemW = $bits(item_type);

   // CORDIC arctangent table, Q0.32 of a turn at 2^32 units
   function automatic logic signed [31:0] atan_tab(input logic [3:0] i);
      logic signed [31:0] r;
      begin
         case (i)
            4'd0:    r = 32'h20000000;
            4'd1:    r = 32'h12E4051E;
            4'd2:    r = 32'h09FB385B;
            4'd3:    r = 32'h051111D4;
            4'd4:    r = 32'h028B0D43;
            4'd5:    r = 32'h0145D7E1;
            4'd6:    r = 32'h00A2F61E;
            4'd7:    r = 32'h00517C55;
            4'd8:    r = 32'h0028BE53;
            4'd9:    r = 32'h00145F2F;
            4'd10:   r = 32'h000A2F98;
            4'd11:   r = 32'h000517CC;
            4'd12:   r = 32'h00028BE6;
            4'd13:   r = 32'h000145F3;
            4'd14:   r = 32'h0000A2FA;
            4'd15:   r = 32'h0000517D;
            default: r = 32'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

/* sv/pspr_ram.sv */
module pspr_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pspr_fifo.sv */
module pspr_fifo
   import pspr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type head,
   output logic     empty
);

   localparam int Depth = 4;

   item_type    slot_ff [Depth];
   logic [1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]  cnt_ff, cnt_in;

   assign full  = (cnt_ff == 3'(Depth));
   assign empty = (cnt_ff == 3'd0);
   assign head  = slot_ff[rp_ff];

   // Advance pointers and count
   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_item;
      end
   end

endmodule

/* sv/pspr_front.sv */
module pspr_front
   import pspr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  init_skip,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [47:0] req_stamp,
   input  logic        req_first_of_scan,
   input  logic [31:0] req_x,
   input  logic [31:0] req_y,
   input  logic [31:0] req_z,
   input  logic [15:0] req_roll,
   input  logic [15:0] req_pitch,
   input  logic [15:0] req_yaw,
   output logic        pose_wr,
   output logic [RingAw-1:0] pose_addr,
   output logic [PoseW-1:0]  pose_data,
   output logic [RingAw-1:0] newest,
   output logic        q_push,
   output item_type    q_item,
   input  logic        q_full,
   input  logic        q_empty
);

   logic [RingAw-1:0] wi_ff, wi_in;
   logic              have_ff, have_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              started_ff, started_in;
   logic              acc_ff, acc_in;
   logic              take, is_pose, first;

   // Hold a pose back while queued points may still walk the ring
   assign req_ready = !q_full && !(is_pose && !q_empty);
   assign take      = req_valid && req_ready;
   assign is_pose   = (req_action == ActPose);
   assign first     = (req_action == ActPoint) && req_first_of_scan;

   assign pose_wr   = take && is_pose;
   assign pose_addr = wi_ff + RingAw'(1);
   assign pose_data = {req_stamp, req_x, req_y, req_z, req_roll, req_pitch, req_yaw};
   assign newest    = wi_ff;

   // Classify scans: start-up counting, pose presence
   always_comb begin
      wi_in      = pose_wr ? pose_addr : wi_ff;
      have_in    = have_ff || pose_wr;
      cnt_in     = cnt_ff;
      started_in = started_ff;
      acc_in     = acc_ff;
      if (take && first) begin
         if (!started_ff) begin
            if (cnt_ff >= init_skip) started_in = 1'b1;
            else cnt_in = cnt_ff + 4'd1;
            acc_in = 1'b0;
         end else begin
            acc_in = have_ff;
         end
      end
   end

   // Queue scan starts and points of accepted scans
   always_comb begin
      q_item.is_scan  = first && started_ff && have_ff;
      q_item.is_point = acc_in;
      q_item.stamp    = req_stamp;
      q_item.x        = req_x;
      q_item.y        = req_y;
      q_item.z        = req_z;
      q_push          = take && !is_pose && acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff      <= RingAw'(RingDepth - 1);
         have_ff    <= 1'b0;
         cnt_ff     <= '0;
         started_ff <= 1'b0;
         acc_ff     <= 1'b0;
      end else if (take) begin
         wi_ff      <= wi_in;
         have_ff    <= have_in;
         cnt_ff     <= cnt_in;
         started_ff <= started_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

/* sv/pspr_back.sv */
module pspr_back
   import pspr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  item_type          head,
   input  logic              empty,
   output logic              pop,
   input  logic [RingAw-1:0] newest,
   output logic [RingAw-1:0] rd_addr,
   input  logic [PoseW-1:0]  rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_out_x,
   output logic [31:0]       rsp_out_y,
   output logic [31:0]       rsp_out_z,
   output logic [47:0]       rsp_pose_stamp
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_WREQ  = 9'b000000010,
      S_WCHK  = 9'b000000100,
      S_FETCH = 9'b000001000,
      S_LATCH = 9'b000010000,
      S_CORD  = 9'b000100000,
      S_MAT   = 9'b001000000,
      S_MUL   = 9'b010000000,
      S_SUM   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [RingAw-1:0] ri_ff, ri_in;
   logic [RingAw-1:0] nxt;
   logic [47:0]       ps_ff;
   logic signed [31:0] t_ff [3];
   logic signed [15:0] ang_ff [3];
   logic [1:0]        ai_ff;
   logic [3:0]        it_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [33:0] cz_ff;
   logic              neg_ff;
   logic signed [17:0] cs_ff [3];
   logic signed [17:0] sn_ff [3];
   logic signed [17:0] r_ff [9];
   logic [3:0]        mi_ff;
   logic [1:0]        row_ff;
   logic [1:0]        col_ff;
   logic signed [51:0] acc_ff;
   logic signed [35:0] pr_ff;
   logic signed [31:0] sg_ff [2];
   logic signed [31:0] o_ff [3];
   logic              ov_ff;
   logic [47:0]       ost_ff;

   assign nxt     = ri_ff + RingAw'(1);
   assign rd_addr = (state_ff == S_WREQ) ? nxt : ri_ff;
   assign rsp_valid      = ov_ff;
   assign rsp_out_x      = o_ff[0];
   assign rsp_out_y      = o_ff[1];
   assign rsp_out_z      = o_ff[2];
   assign rsp_pose_stamp = ost_ff;

   // Fold angle into [-pi/2, pi/2]
   function automatic logic signed [16:0] fold(input logic signed [15:0] a);
      logic signed [16:0] b;
      begin
         b = 17'(a);
         if (a > 16'sd16384) b = b - 17'sd32768;
         else if (a < -16'sd16384) b = b + 17'sd32768;
         return b;
      end
   endfunction

   // Round Q2.30 to Q16, clamp, and negate when n is set
   function automatic logic signed [17:0] crnd(input logic signed [33:0] v, input logic n);
      logic signed [33:0] r;
      logic signed [17:0] c;
      begin
         r = (v + 34'sd8192) >>> 14;
         if (r > 34'sd65536) c = 18'sd65536;
         else if (r < -34'sd65536) c = -18'sd65536;
         else c = r[17:0];
         return n ? -c : c;
      end
   endfunction

   // Round Q48 to Q16 entry, saturate to 18 bits
   function automatic logic signed [17:0] ernd(input logic signed [53:0] v);
      logic signed [53:0] r;
      begin
         r = (v + (54'sd1 <<< 31)) >>> 32;
         if (r > 54'sd131071) return 18'sd131071;
         else if (r < -54'sd131072) return -18'sd131072;
         else return r[17:0];
      end
   endfunction

   // Matrix entry mi from sines/cosines (roll 0, pitch 1, yaw 2); one product pair
   logic signed [35:0] pa, pb;
   logic signed [53:0] ent;
   logic signed [17:0] cr, sr, cp, sp, cyw, syw;
   logic signed [35:0] cysp_ff, sysp_ff;
   assign cr = cs_ff[0]; assign sr = sn_ff[0];
   assign cp = cs_ff[1]; assign sp = sn_ff[1];
   assign cyw = cs_ff[2]; assign syw = sn_ff[2];

   // Register the yaw-pitch products ahead of the matrix build
   always_ff @(posedge clock) begin
      cysp_ff <= cyw * sp;
      sysp_ff <= syw * sp;
   end

   always_comb begin
      pa  = '0;
      ent = '0;
      case (mi_ff)
         4'd0: ent = 54'(cyw * cp) <<< 16;
         4'd1: ent = 54'(cysp_ff) * 54'(sr) - (54'(syw * cr) <<< 16);
         4'd2: ent = 54'(cysp_ff) * 54'(cr) + (54'(syw * sr) <<< 16);
         4'd3: ent = 54'(syw * cp) <<< 16;
         4'd4: ent = 54'(sysp_ff) * 54'(sr) + (54'(cyw * cr) <<< 16);
         4'd5: ent = 54'(sysp_ff) * 54'(cr) - (54'(cyw * sr) <<< 16);
         4'd6: ent = -(54'(sp) <<< 32);
         4'd7: ent = 54'(cp * sr) <<< 16;
         4'd8: ent = 54'(cp * cr) <<< 16;
         default: pa = '0;
      endcase
   end
   assign pb = pa;

   // Point product: one entry times one coordinate per cycle
   logic signed [31:0] pc;
   logic signed [49:0] prod;
   always_comb begin
      case (col_ff)
         2'd0:    pc = head.x;
         2'd1:    pc = head.y;
         default: pc = head.z;
      endcase
   end
   assign prod = r_ff[{2'b0, row_ff} * 4'd3 + {2'b0, col_ff}] * pc;

   logic signed [51:0] sum_r;
   logic signed [51:0] fin;
   always_comb begin
      sum_r = ((acc_ff + 52'sd32768) >>> 16) + 52'(t_ff[row_ff]);
      if (sum_r > 52'sd2147483647) fin = 52'sd2147483647;
      else if (sum_r < -52'sd2147483648) fin = -52'sd2147483648;
      else fin = sum_r;
   end

   logic signed [33:0] dx, dy;
   assign dx = cy_ff >>> it_ff;
   assign dy = cx_ff >>> it_ff;

   logic out_free;
   assign out_free = !ov_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      ri_in    = ri_ff;
      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               if (head.is_scan) state_in = S_WREQ;
               else if (head.is_point) state_in = S_MUL;
               else pop = 1'b1;
            end
         end
         S_WREQ: state_in = (ri_ff == newest) ? S_FETCH : S_WCHK;
         S_WCHK: begin
            if (rd_data[PoseW-1 -: 48] < head.stamp) begin
               ri_in    = nxt;
               state_in = S_WREQ;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: state_in = S_LATCH;
         S_LATCH: state_in = S_CORD;
         S_CORD:  if (it_ff == 4'd15 && ai_ff == 2'd2) state_in = S_MAT;
         S_MAT:   if (mi_ff == 4'd8) state_in = S_MUL;
         S_MUL:   if (col_ff == 2'd2) state_in = S_SUM;
         S_SUM: begin
            if (row_ff != 2'd2) state_in = S_MUL;
            else if (out_free) begin
               state_in = S_IDLE;
               pop      = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ri_ff    <= '0;
         ov_ff    <= 1'b0;
         for (int i = 0; i < 9; i++) r_ff[i] <= '0;
         for (int i = 0; i < 3; i++) t_ff[i] <= '0;
         ps_ff  <= '0;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         state_ff <= state_in;
         ri_ff    <= ri_in;
         // Raise valid on a finished point, drop it once transferred
         ov_ff    <= (state_ff == S_SUM && row_ff == 2'd2 && out_free) ||
                     (ov_ff && !rsp_ready);
         case (state_ff)
            S_LATCH: begin
               ps_ff     <= rd_data[PoseW-1 -: 48];
               t_ff[0]   <= rd_data[143:112];
               t_ff[1]   <= rd_data[111:80];
               t_ff[2]   <= rd_data[79:48];
               ang_ff[0] <= rd_data[47:32];
               ang_ff[1] <= rd_data[31:16];
               ang_ff[2] <= rd_data[15:0];
               ai_ff     <= 2'd0;
               it_ff     <= 4'd0;
               cx_ff     <= 34'sh026DD3B6A;
               cy_ff     <= '0;
               cz_ff     <= 34'(fold(rd_data[47:32])) <<< 16;
               neg_ff    <= (fold(rd_data[47:32]) != 17'(signed'(rd_data[47:32])));
            end
            S_CORD: begin
               if (it_ff == 4'd15) begin
                  cs_ff[ai_ff] <= crnd((cz_ff >= 0) ? cx_ff - dx : cx_ff + dx, neg_ff);
                  sn_ff[ai_ff] <= crnd((cz_ff >= 0) ? cy_ff + dy : cy_ff - dy, neg_ff);
                  ai_ff  <= ai_ff + 2'd1;
                  cx_ff  <= 34'sh026DD3B6A;
                  cy_ff  <= '0;
                  cz_ff  <= 34'(fold(ang_ff[ai_ff + 2'd1])) <<< 16;
                  neg_ff <= (fold(ang_ff[ai_ff + 2'd1]) != 17'(ang_ff[ai_ff + 2'd1]));
               end else if (cz_ff >= 0) begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - 34'(atan_tab(it_ff));
               end else begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + 34'(atan_tab(it_ff));
               end
               it_ff <= it_ff + 4'd1;
               mi_ff <= '0;
            end
            S_MAT: begin
               r_ff[mi_ff] <= ernd(ent + 54'(pb));
               mi_ff       <= mi_ff + 4'd1;
            end
            S_MUL: begin
               acc_ff <= ((col_ff == 2'd0) ? 52'sd0 : acc_ff) + 52'(prod);
               col_ff <= (col_ff == 2'd2) ? 2'd0 : col_ff + 2'd1;
            end
            S_SUM: begin
               // Stage the first two rows, publish all three together
               if (row_ff != 2'd2) begin
                  sg_ff[row_ff[0]] <= fin[31:0];
                  row_ff           <= row_ff + 2'd1;
               end else if (out_free) begin
                  o_ff[0] <= sg_ff[0];
                  o_ff[1] <= sg_ff[1];
                  o_ff[2] <= fin[31:0];
                  ost_ff  <= ps_ff;
                  row_ff  <= 2'd0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

/* sv/pose_synced_point_registration.sv */
// A point's result is registered at the output after its item passes the idle state and
// three rows of three multiply steps and a sum step (the last waits for a free output);
// the first point of a scan adds the pointer walk (a request and a check per pose stepped
// over) and the matrix build (3 x 16 CORDIC iterations plus 9 entries). The back end
// holds one point at a time and pops it as its result goes out; a 4-entry queue buffers
// points and a pose waits until it is empty. Reset is synchronous, ring unreset.
module pose_synced_point_registration
   import pspr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [47:0] req_stamp,
   input  logic        req_first_of_scan,
   input  logic [31:0] req_x,
   input  logic [31:0] req_y,
   input  logic [31:0] req_z,
   input  logic [15:0] req_roll,
   input  logic [15:0] req_pitch,
   input  logic [15:0] req_yaw,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic [47:0] rsp_pose_stamp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [3:0]        skip_ff;
   logic              pose_wr, q_push, q_full, q_empty, q_pop;
   logic [RingAw-1:0] pose_addr, newest, rd_addr;
   logic [PoseW-1:0]  pose_data, rd_data;
   item_type          q_item, q_head;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == RegInitSkip) ? {28'd0, skip_ff} : 32'd0;

   // Register write transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 4'd5;
      end else if (psel && penable && pwrite && paddr[2] == RegInitSkip) begin
         skip_ff <= pwdata[3:0];
      end
   end

   pspr_front u_front (
      .clock, .reset, .init_skip(skip_ff),
      .req_valid, .req_ready, .req_action, .req_stamp, .req_first_of_scan,
      .req_x, .req_y, .req_z, .req_roll, .req_pitch, .req_yaw,
      .pose_wr, .pose_addr, .pose_data, .newest,
      .q_push, .q_item, .q_full, .q_empty
   );

   pspr_ram #(.Width(PoseW), .Depth(RingDepth)) u_ring (
      .clock, .wr_en(pose_wr), .wr_addr(pose_addr), .wr_data(pose_data),
      .rd_addr, .rd_data
   );

   pspr_fifo u_fifo (
      .clock, .reset, .push(q_push), .push_item(q_item), .full(q_full),
      .pop(q_pop), .head(q_head), .empty(q_empty)
   );

   pspr_back u_back (
      .clock, .reset, .head(q_head), .empty(q_empty), .pop(q_pop),
      .newest, .rd_addr, .rd_data,
      .rsp_valid, .rsp_ready, .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_pose_stamp
   );

endmodule

/* verif/tb_pose_synced_point_registration.sv */
`timescale 1ns / 100ps

import pspr_pkg::*;

typedef struct {
   logic [31:0] x;
   logic [31:0] y;
   logic [31:0] z;
   logic [47:0] stamp;
} reg_point_type;

class registration_scoreboard;
   localparam int Depth = 256;

   // pose ring and scan state
   bit [47:0]   ring_stamp [Depth];
   int          ring_pos [Depth][3];
   int          ring_ang [Depth][3];
   int unsigned wr_idx;
   int unsigned rd_idx;
   bit          have_pose;
   int unsigned start_cnt;
   bit          started;
   bit          scan_live;
   longint      rot [9];
   longint      trans [3];
   bit [47:0]   scan_stamp;
   int unsigned init_skip;

   reg_point_type expected_points [$];
   int          errors;

   function new();
      wr_idx = Depth - 1;
      rd_idx = 0;
      init_skip = 5;
      foreach (rot[i]) rot[i] = 0;
      foreach (trans[i]) trans[i] = 0;
   endfunction

   function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // CORDIC sine and cosine, Q16 result
   function void sin_cos(int a, output longint c, output longint s);
      longint atan_q30 [16] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
      longint cx, sy, ang, nx, dx, dy;
      bit flip;
      cx = 64'h26DD3B6A;
      sy = 0;
      flip = 0;
      if (a > 16384) begin
         a -= 32768;
         flip = 1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1;
      end
      ang = longint'(a) * 65536;
      for (int i = 0; i < 16; i++) begin
         dx = sy >>> i;
         dy = cx >>> i;
         if (ang >= 0) begin
            nx = cx - dx;
            sy = sy + dy;
            ang -= atan_q30[i];
         end else begin
            nx = cx + dx;
            sy = sy - dy;
            ang += atan_q30[i];
         end
         cx = nx;
      end
      cx = clamp((cx + 8192) >>> 14, -65536, 65536);
      sy = clamp((sy + 8192) >>> 14, -65536, 65536);
      if (flip) begin
         cx = -cx;
         sy = -sy;
      end
      c = cx;
      s = sy;
   endfunction

   function longint round_entry(longint q48);
      return clamp((q48 + (64'sd1 <<< 31)) >>> 32, -131072, 131071);
   endfunction

   function void build_rotation(int roll, int pitch, int yaw);
      longint cr, sr, cp, sp, cy, sy;
      longint one;
      one = 65536;
      sin_cos(roll, cr, sr);
      sin_cos(pitch, cp, sp);
      sin_cos(yaw, cy, sy);
      rot[0] = round_entry(cy * cp * one);
      rot[1] = round_entry(cy * sp * sr - sy * cr * one);
      rot[2] = round_entry(cy * sp * cr + sy * sr * one);
      rot[3] = round_entry(sy * cp * one);
      rot[4] = round_entry(sy * sp * sr + cy * cr * one);
      rot[5] = round_entry(sy * sp * cr - cy * sr * one);
      rot[6] = round_entry(-sp * one * one);
      rot[7] = round_entry(cp * sr * one);
      rot[8] = round_entry(cp * cr * one);
   endfunction

   // count start-up scans, walk the read pointer, latch the pose
   function bit open_scan(bit [47:0] stamp);
      int unsigned nxt;
      if (!started) begin
         if (start_cnt >= init_skip) started = 1;
         else start_cnt = (start_cnt + 1) & 4'hF;
         return 0;
      end
      if (!have_pose) return 0;
      for (int n = 0; n < Depth; n++) begin
         if (rd_idx == wr_idx) break;
         nxt = (rd_idx + 1) % Depth;
         if (!(ring_stamp[nxt] < stamp)) break;
         rd_idx = nxt;
      end
      build_rotation(ring_ang[rd_idx][0], ring_ang[rd_idx][1], ring_ang[rd_idx][2]);
      foreach (trans[i]) trans[i] = ring_pos[rd_idx][i];
      scan_stamp = ring_stamp[rd_idx];
      return 1;
   endfunction

   function void note_item(bit action, bit [47:0] stamp, bit first,
                           bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                           bit [15:0] roll, bit [15:0] pitch, bit [15:0] yaw);
      longint p [3];
      longint acc, v;
      reg_point_type r;
      bit [31:0] res [3];
      p[0] = longint'($signed(px));
      p[1] = longint'($signed(py));
      p[2] = longint'($signed(pz));
      if (action == ActPose) begin
         wr_idx = (wr_idx + 1) % Depth;
         ring_stamp[wr_idx] = stamp;
         foreach (p[i]) ring_pos[wr_idx][i] = int'(p[i]);
         ring_ang[wr_idx][0] = int'($signed(roll));
         ring_ang[wr_idx][1] = int'($signed(pitch));
         ring_ang[wr_idx][2] = int'($signed(yaw));
         have_pose = 1;
         return;
      end
      if (first) scan_live = open_scan(stamp);
      if (!scan_live) return;
      for (int k = 0; k < 3; k++) begin
         acc = rot[3*k] * p[0] + rot[3*k+1] * p[1] + rot[3*k+2] * p[2];
         v = ((acc + 32768) >>> 16) + trans[k];
         res[k] = 32'(clamp(v, -64'sd2147483648, 64'sd2147483647));
      end
      r.x = res[0];
      r.y = res[1];
      r.z = res[2];
      r.stamp = scan_stamp;
      expected_points.insert(expected_points.size(), r);
   endfunction

   function void check_result(reg_point_type got);
      reg_point_type exp_pt;
      if (expected_points.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected result x=%h y=%h z=%h stamp=%h",
                     got.x, got.y, got.z, got.stamp);
         return;
      end
      exp_pt = expected_points.pop_front();
      if (got.x !== exp_pt.x || got.y !== exp_pt.y || got.z !== exp_pt.z
          || got.stamp !== exp_pt.stamp) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp x=%h y=%h z=%h stamp=%h, got x=%h y=%h z=%h stamp=%h",
                     exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.stamp,
                     got.x, got.y, got.z, got.stamp);
      end
   endfunction
endclass

module tb_pose_synced_point_registration;
   localparam int LimitCycles = 600000;
   localparam int DrainCycles = 1200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [47:0] req_stamp;
   logic        req_first_of_scan;
   logic [31:0] req_x, req_y, req_z;
   logic [15:0] req_roll, req_pitch, req_yaw;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [47:0] rsp_pose_stamp;
   logic        psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   registration_scoreboard sb;
   int          cycle_count;
   int          burst_left;
   int          hold_request;
   logic [47:0] now_us;

   pose_synced_point_registration u_dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LimitCycles) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: stall pattern, with one long hold-off on request
   initial begin
      int mode, hold;
      rsp_ready = 0;
      hold = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
         end
         if (cycle_count % 97 == 0) mode = $urandom_range(0, 3);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 0;
         end else begin
            case (mode)
               0: rsp_ready <= 1;
               1: rsp_ready <= $urandom_range(0, 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (cycle_count % 5 != 0);
            endcase
         end
      end
   end

   // check each transfer on the result channel
   always @(posedge clock) begin
      reg_point_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.x = rsp_out_x;
         got.y = rsp_out_y;
         got.z = rsp_out_z;
         got.stamp = rsp_pose_stamp;
         sb.check_result(got);
      end
   end

   // offer one item, in bursts with random gaps; returns at a falling edge
   task automatic send(bit action, bit [47:0] stamp, bit first,
                       bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                       bit [15:0] roll, bit [15:0] pitch, bit [15:0] yaw);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_action <= action;
      req_stamp <= stamp;
      req_first_of_scan <= first;
      req_x <= px;
      req_y <= py;
      req_z <= pz;
      req_roll <= roll;
      req_pitch <= pitch;
      req_yaw <= yaw;
      do @(posedge clock); while (!req_ready);
      sb.note_item(action, stamp, first, px, py, pz, roll, pitch, yaw);
      @(negedge clock);
   endtask

   task automatic send_pose(bit [47:0] stamp, bit [31:0] px, bit [31:0] py,
                            bit [31:0] pz, bit [15:0] roll, bit [15:0] pitch,
                            bit [15:0] yaw);
      send(ActPose, stamp, 1'($urandom_range(0, 1)), px, py, pz, roll, pitch, yaw);
   endtask

   task automatic send_point(bit [47:0] stamp, bit first, bit [31:0] px,
                             bit [31:0] py, bit [31:0] pz);
      send(ActPoint, stamp, first, px, py, pz,
           16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   function automatic bit [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   // write the register once the block has gone quiet
   task automatic write_init_skip(bit [3:0] value);
      req_valid <= 0;
      while (sb.expected_points.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      psel <= 1;
      pwrite <= 1;
      paddr <= 3'(4 * RegInitSkip);
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      sb.init_skip = value;
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic random_scan();
      int pts;
      bit [47:0] sstamp;
      sstamp = ($urandom_range(0, 3) == 0) ? now_us + $urandom_range(0, 500)
                                           : now_us - $urandom_range(0, 4000);
      pts = $urandom_range(1, 8);
      for (int i = 0; i < pts; i++) begin
         // poses may land mid-scan
         if (i > 0 && $urandom_range(0, 5) == 0) random_pose();
         send_point(sstamp, i == 0, rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   task automatic random_pose();
      now_us += $urandom_range(1, 1500);
      send_pose(now_us, rand_coord(), rand_coord(), rand_coord(),
                16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      int sent;
      bit [15:0] angs [8] = '{16'h0000, 16'h4000, 16'h4001, 16'hC000,
                              16'hBFFF, 16'h7FFF, 16'h8000, 16'h2000};
      sb = new();
      cycle_count = 0;
      burst_left = 0;
      hold_request = 0;
      reset = 1;
      req_valid = 0;
      req_action = ActPose;
      req_stamp = 0;
      req_first_of_scan = 0;
      req_x = 0;
      req_y = 0;
      req_z = 0;
      req_roll = 0;
      req_pitch = 0;
      req_yaw = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // start-up: stray point, skipped scans, a lowered skip count
      write_init_skip(4'd15);
      send_point(48'd10, 1'b0, 32'h00010000, 0, 0);
      for (int s = 0; s < 3; s++) begin
         send_point(48'd20 + s, 1'b1, 32'h1, 32'h2, 32'h3);
         send_point(48'd20 + s, 1'b0, 32'h4, 32'h5, 32'h6);
      end
      write_init_skip(4'd2);
      send_point(48'd30, 1'b1, 32'h1, 32'h1, 32'h1);
      // started, but no pose yet
      send_point(48'd31, 1'b1, 32'h1, 32'h1, 32'h1);
      send_point(48'd31, 1'b0, 32'h1, 32'h1, 32'h1);

      // poses at extreme angles, then scans with extreme points
      now_us = 48'd1000;
      foreach (angs[i]) begin
         send_pose(now_us, rand_coord(), rand_coord(), rand_coord(),
                   angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8]);
         now_us += 100;
      end
      send_point(48'd0, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_point(48'd0, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000);
      send_point(48'd1250, 1'b1, 32'h00010000, 32'hFFFF0000, 0);
      send_point(48'hFFFFFFFFFFFF, 1'b1, 0, 0, 0);
      send_point(48'hFFFFFFFFFFFF, 1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h12345678);
      send_pose(48'hFFFFFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0,
                16'h7FFF, 16'h8000, 16'h0000);
      send_point(48'hFFFFFFFFFFFF, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
      now_us = 48'd1_000_000;

      // random traffic over several register settings
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_init_skip(4'd0);
            1: write_init_skip(4'd15);
            default: write_init_skip(4'($urandom_range(0, 15)));
         endcase
         if (phase == 1) hold_request = 3000;
         while (sent < 200 * (phase + 1)) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  random_pose();
                  sent++;
               end
               3: begin
                  // noise: stray point or pose at any stamp
                  if ($urandom_range(0, 1))
                     send_point(48'({$urandom, $urandom}), 1'b0,
                                $urandom, $urandom, $urandom);
                  else
                     send_pose(48'({$urandom, $urandom}),
                               $urandom, $urandom, $urandom,
                               16'($urandom), 16'($urandom), 16'($urandom));
                  sent++;
               end
               default: begin
                  random_scan();
                  sent += 4;
               end
            endcase
         end
      end

      // drain
      req_valid <= 0;
      while (sb.expected_points.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/pspr_pkg.sv
sv/pspr_ram.sv
sv/pspr_fifo.sv
sv/pspr_front.sv
sv/pspr_back.sv
sv/pose_synced_point_registration.sv
verif/tb_pose_synced_point_registration.sv
